// ----- rtl/psu_pkg.sv -----
package psu_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int BPP_W      = 4;
  localparam int ROW_LEN_W  = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH      = 2'd1;

  // PNG filter types
  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;

  // per data byte control handed from the column tracker to reconstruction
  typedef struct packed {
    logic [7:0] data;
    logic [2:0] filter;
    logic       a_ok;     // left neighbor lies inside the row
    logic       b_ok;     // not the first row, above neighbor is real
    logic       row_end;
  } s1_ctrl_t;

endpackage

// ----- rtl/png_scanline_unfilter_top.sv -----
// PNG scanline unfilter (filter method 0: None, Sub, Up, Average, Paeth).
// Input channel (in_*): the inflated image stream, one byte per transaction.
//   The first byte of each row is the filter type and produces no output;
//   in_start_of_image marks the filter byte of an image's first row.
// Output channel (out_*): one rebuilt data byte per data transaction, with
//   out_row_end high on the last byte of a row.
// Config channel (cfg_*): index 0 = bytes per pixel, index 1 = row length.
//   cfg_ready is always high; write only while the block is idle.
// Path: a data byte goes through the stage 1 register, then the output register.
// Throughput: one byte per cycle sustained while out_stall stays low. The
//   row store read for column i is issued at accept time and its registered
//   data meets the byte in the reconstruction stage; the write of the rebuilt
//   byte happens as it moves to the output register.
// Stall: out_stall holds the output register; the reconstruction stage
//   still drains into a free output slot, and in_stall rises only when both
//   stages are full.
// Reset (rst_n low, synchronous): control, column tracking and neighbor
//   history clear; the row store is not cleared since above bytes are masked
//   to zero in the first row, which writes every entry the next row reads.
module png_scanline_unfilter_top
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_start_of_image,
  // result stream
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_pixel_byte,
  output logic                  out_row_end,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // config registers
  logic [BPP_W-1:0]     bpp_r;
  logic [ROW_LEN_W-1:0] row_len_r;

  // handshake
  logic in_acc;
  logic s1_adv;

  // column tracker outputs
  logic          is_data;
  s1_ctrl_t      ctrl;
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] bpp_idx;

  // reconstruction stage register
  logic          s1_v_r, s1_v_nxt;
  s1_ctrl_t      s1_ctrl_r;
  logic [AW-1:0] s1_addr_r;
  logic [PW-1:0] s1_bpp_idx_r;

  // output register
  logic       out_v_r, out_v_nxt;
  logic [7:0] out_pixel_r;
  logic       out_row_end_r;

  logic [7:0] above;
  logic [7:0] pixel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r     <= BPP_W'(1);
      row_len_r <= ROW_LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BYTES_PER_PIXEL: bpp_r     <= cfg_data[BPP_W-1:0];
        REG_ROW_LENGTH:      row_len_r <= cfg_data[ROW_LEN_W-1:0];
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  // Stage 1 moves on whenever the output slot is empty or being taken.
  assign s1_adv   = !out_v_r || !out_stall;
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  psu_ctrl #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_acc),
    .data_byte     (in_data_byte),
    .start_of_image(in_start_of_image),
    .cfg_bpp       (bpp_r),
    .cfg_row_len   (row_len_r),
    .is_data       (is_data),
    .ctrl          (ctrl),
    .rd_addr       (rd_addr),
    .bpp_idx       (bpp_idx)
  );

  // Row store: read at accept, written as the rebuilt byte leaves stage 1.
  psu_ram #(
    .WIDTH(8),
    .DEPTH(MAX_ROW_BYTES)
  ) u_row_store (
    .clk  (clk),
    .we   (s1_v_r && s1_adv),
    .waddr(s1_addr_r),
    .wdata(pixel),
    .re   (in_acc && is_data),
    .raddr(rd_addr),
    .rdata(above)
  );

  always_comb begin
    if (in_acc) begin
      s1_v_nxt = is_data;     // filter bytes stop at the column tracker
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_data) begin
      s1_ctrl_r    <= ctrl;
      s1_addr_r    <= rd_addr;
      s1_bpp_idx_r <= bpp_idx;
    end
  end

  psu_recon #(
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_recon (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (s1_ctrl_r),
    .bpp_idx (s1_bpp_idx_r),
    .above   (above),
    .shift_en(s1_v_r && s1_adv),
    .pixel   (pixel)
  );

  assign out_v_nxt = s1_adv ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s1_adv) begin
      out_pixel_r   <= pixel;
      out_row_end_r <= s1_ctrl_r.row_end;
    end
  end

  assign out_valid      = out_v_r;
  assign out_pixel_byte = out_pixel_r;
  assign out_row_end    = out_row_end_r;

  // A held stage 1 keeps its byte and its row store address.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(s1_ctrl_r) && $stable(s1_addr_r)))
    else $error("stage 1 item changed while held");

  // An accepted data byte always reaches stage 1.
  a_data_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_data) |=> s1_v_r)
    else $error("accepted data byte lost before reconstruction");

  // A filter byte never creates a reconstruction slot.
  a_filter_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !is_data) |=> !s1_v_r)
    else $error("filter byte entered reconstruction stage");

endmodule

// ----- rtl/psu_ram.sv -----
module psu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/psu_ctrl.sv -----
module psu_ctrl
  import psu_pkg::*;
#(
  parameter int MAX_ROW_BYTES   = psu_pkg::MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic [7:0]           data_byte,
  input  logic                 start_of_image,
  input  logic [BPP_W-1:0]     cfg_bpp,
  input  logic [ROW_LEN_W-1:0] cfg_row_len,
  output logic                 is_data,
  output s1_ctrl_t             ctrl,
  output logic [((MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1)-1:0] rd_addr,
  output logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] bpp_idx
);

  localparam int CW = $clog2(MAX_ROW_BYTES + 1);
  localparam int AW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic [CW-1:0]    col_r, col_nxt;        // 0: expecting filter byte
  logic [2:0]       filter_r, filter_nxt;
  logic             first_r, first_nxt;
  logic [BPP_W-1:0] eff_bpp;
  logic [CW-1:0]    eff_len;
  logic [31:0]      len32;
  logic             row_end;

  always_comb begin
    if (cfg_bpp == '0) begin
      eff_bpp = BPP_W'(1);
    end else if (cfg_bpp > BPP_W'(MAX_PIXEL_BYTES)) begin
      eff_bpp = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      eff_bpp = cfg_bpp;
    end
  end

  always_comb begin
    len32 = 32'(cfg_row_len);
    if (len32 == 32'd0) begin
      eff_len = CW'(1);
    end else if (len32 > 32'(MAX_ROW_BYTES)) begin
      eff_len = CW'(MAX_ROW_BYTES);
    end else begin
      eff_len = CW'(len32);
    end
  end

  assign is_data = !start_of_image && (col_r != '0);
  assign row_end = (col_r >= eff_len);
  assign rd_addr = AW'(col_r - CW'(1));
  assign bpp_idx = PW'(eff_bpp - BPP_W'(1));

  assign ctrl.data    = data_byte;
  assign ctrl.filter  = filter_r;
  assign ctrl.a_ok    = (col_r > CW'(eff_bpp));
  assign ctrl.b_ok    = !first_r;
  assign ctrl.row_end = row_end;

  always_comb begin
    col_nxt    = col_r;
    filter_nxt = filter_r;
    first_nxt  = first_r;
    if (accept) begin
      if (!is_data) begin
        if (start_of_image) begin
          first_nxt = 1'b1;
        end
        filter_nxt = (data_byte <= {5'd0, FLT_PAETH}) ? data_byte[2:0] : FLT_NONE;
        col_nxt    = CW'(1);
      end else if (row_end) begin
        col_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      filter_r <= FLT_NONE;
      first_r  <= 1'b1;
    end else begin
      col_r    <= col_nxt;
      filter_r <= filter_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

// ----- rtl/psu_recon.sv -----
module psu_recon
  import psu_pkg::*;
#(
  parameter int MAX_PIXEL_BYTES = psu_pkg::MAX_PIXEL_BYTES
) (
  input  logic       clk,
  input  logic       rst_n,
  input  s1_ctrl_t   ctrl,
  input  logic [((MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1)-1:0] bpp_idx,
  input  logic [7:0] above,
  input  logic       shift_en,
  output logic [7:0] pixel
);

  logic [7:0] left_r [MAX_PIXEL_BYTES];
  logic [7:0] ul_r   [MAX_PIXEL_BYTES];
  logic [7:0] a, b, c;
  logic [7:0] pa, pb;
  logic [8:0] pc, ab, c2, sum9;
  logic [7:0] pred;

  assign a = ctrl.a_ok ? left_r[bpp_idx] : 8'd0;
  assign b = ctrl.b_ok ? above : 8'd0;
  assign c = (ctrl.a_ok && ctrl.b_ok) ? ul_r[bpp_idx] : 8'd0;

  // Paeth distances: |b-c|, |a-c|, |a+b-2c|
  always_comb begin
    pa = (b > c) ? (b - c) : (c - b);
    pb = (a > c) ? (a - c) : (c - a);
    ab = {1'b0, a} + {1'b0, b};
    c2 = {c, 1'b0};
    pc = (ab > c2) ? (ab - c2) : (c2 - ab);
  end

  always_comb begin
    sum9 = {1'b0, a} + {1'b0, b};
    unique case (ctrl.filter)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = sum9[8:1];
      FLT_PAETH: begin
        if (pa <= pb && {1'b0, pa} <= pc) begin
          pred = a;
        end else if ({1'b0, pb} <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:   pred = 8'd0;
    endcase
  end

  assign pixel = ctrl.data + pred;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        left_r[k] <= 8'd0;
        ul_r[k]   <= 8'd0;
      end
    end else if (shift_en) begin
      for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_r[k] <= left_r[k-1];
        ul_r[k]   <= ul_r[k-1];
      end
      left_r[0] <= pixel;
      ul_r[0]   <= b;
    end
  end

endmodule

// ----- tb/sv/png_scanline_unfilter_top_test.sv -----
`timescale 1ns / 1ps

module png_scanline_unfilter_top_test;
  import psu_pkg::*;

  // Config indexes that map to no register; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Filter codes past Paeth: the block treats them as None.
  localparam logic [7:0] FLT_CODE_FIRST_UNKNOWN = 8'd5;
  localparam logic [7:0] FLT_CODE_TOP           = 8'hFF;

  // Flavors of random row content.
  localparam int DATA_ANY   = 0;  // uniform bytes
  localparam int DATA_EDGES = 1;  // 00/01/7F/80/FE/FF, wrap and tie heavy
  localparam int DATA_NEAR  = 2;  // 0..3, forces Paeth ties

  localparam int IDLE_MAX = 12;
  localparam int LONG_ROW = 256;

  // One expected pixel transaction.
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
  } pixel_exp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = '0;
  logic                  in_start_of_image = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_pixel_byte;
  logic                  out_row_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  png_scanline_unfilter_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_start_of_image (in_start_of_image),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_byte    (out_pixel_byte),
    .out_row_end       (out_row_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of what the block holds, at reset values.
  // ---------------------------------------------------------------------------
  logic [BPP_W-1:0]     cfg_bpp     = BPP_W'(1);
  logic [ROW_LEN_W-1:0] cfg_row_len = ROW_LEN_W'(1);
  logic [7:0]  row_mem    [MAX_ROW_BYTES]   = '{default: 8'h00};  // last rebuilt row
  logic [7:0]  left_hist  [MAX_PIXEL_BYTES] = '{default: 8'h00};  // rebuilt bytes, newest first
  logic [7:0]  above_hist [MAX_PIXEL_BYTES] = '{default: 8'h00};  // "above" bytes, newest first
  int unsigned col_cnt       = 0;  // 0: filter byte next, else 1-based data column
  logic [2:0]  cur_filter    = FLT_NONE;
  logic        in_first_row  = 1'b1;

  pixel_exp_t  expected_pixels [$];

  // Traffic shaping: per-transaction idle draws are 0..max on each side.
  int unsigned tx_max = IDLE_MAX;
  int unsigned rx_max = IDLE_MAX;
  // Set whenever the next row has to open a fresh image (after a raised row
  // length or a deliberately truncated row) so no unwritten row store entry
  // is ever read.
  logic        need_sof = 1'b0;

  int unsigned bytes_sent     = 0;
  int unsigned pixels_checked = 0;
  int unsigned rows_closed    = 0;
  int unsigned fail_count     = 0;
  pixel_exp_t  head_pix;

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog well beyond the slowest legal run; reaching it fails the test.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  // Effective data bytes per row: 0 acts as 1, oversize clamps to the store.
  function automatic int unsigned row_span();
    if (cfg_row_len == 0) return 1;
    if (cfg_row_len > MAX_ROW_BYTES) return MAX_ROW_BYTES;
    return cfg_row_len;
  endfunction

  // Paeth: neighbor closest to a+b-c, ties go to a then b.
  function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    int pa, pb, pc;
    pa = int'(b) - int'(c);
    pb = int'(a) - int'(c);
    pc = int'(a) + int'(b) - 2 * int'(c);
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    if (pc < 0) pc = -pc;
    if (pa <= pb && pa <= pc) return a;
    if (pb <= pc) return b;
    return c;
  endfunction

  // Advance the predictor by one accepted stream byte; data bytes queue the
  // pixel they should rebuild to.
  task automatic unfilter_byte(input logic [7:0] x, input logic sof);
    int unsigned bpp, len, col;
    logic [7:0]  a, b, c, r;
    logic [8:0]  sum;
    pixel_exp_t  item;
    if (sof || col_cnt == 0) begin
      // filter type byte: a start mark always opens a new first row
      if (sof) in_first_row = 1'b1;
      cur_filter = (x <= FLT_PAETH) ? x[2:0] : FLT_NONE;
      col_cnt    = 1;
      left_hist  = '{default: 8'h00};
      above_hist = '{default: 8'h00};
      return;
    end
    bpp = (cfg_bpp == 0) ? 1 : ((cfg_bpp > MAX_PIXEL_BYTES) ? MAX_PIXEL_BYTES : cfg_bpp);
    len = row_span();
    col = col_cnt;
    // left and upper-left are zero inside the first pixel; above is zero in row one
    a = (col > bpp) ? left_hist[bpp-1] : 8'h00;
    b = in_first_row ? 8'h00 : row_mem[col-1];
    c = (col > bpp && !in_first_row) ? above_hist[bpp-1] : 8'h00;
    sum = {1'b0, a} + {1'b0, b};
    case (cur_filter)
      FLT_SUB:   r = x + a;
      FLT_UP:    r = x + b;
      FLT_AVG:   r = x + sum[8:1];
      FLT_PAETH: r = x + paeth_pick(a, b, c);
      default:   r = x;
    endcase
    for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
      left_hist[k]  = left_hist[k-1];
      above_hist[k] = above_hist[k-1];
    end
    left_hist[0]   = r;
    above_hist[0]  = b;
    row_mem[col-1] = r;
    item.pixel_byte = r;
    item.row_end    = (col >= len);
    expected_pixels.insert(expected_pixels.size(), item);
    // a row length lowered mid row ends the row on the next data byte
    if (col >= len) begin
      col_cnt      = 0;
      in_first_row = 1'b0;
    end else begin
      col_cnt = col + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall ahead of every transaction, checker on accept.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    forever begin
      hold = (rx_max == 0) ? 0 : $urandom_range(rx_max, 0);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel transaction: pixel_byte %0h row_end %0b",
               out_pixel_byte, out_row_end);
        fail_count++;
      end else begin
        head_pix = expected_pixels.pop_front();
        pixels_checked++;
        if (head_pix.row_end) rows_closed++;
        if (out_pixel_byte !== head_pix.pixel_byte) begin
          $error("pixel_byte expected %0h, got %0h", head_pix.pixel_byte, out_pixel_byte);
          fail_count++;
        end
        if (out_row_end !== head_pix.row_end) begin
          $error("row_end expected %0b, got %0b", head_pix.row_end, out_row_end);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. All of them start and end just after a falling edge.
  // ---------------------------------------------------------------------------
  // One stream transaction. valid stays high into the next call when that
  // call draws no idle cycles, so back-to-back traffic is really seen.
  task automatic send_byte(input logic [7:0] value, input logic sof);
    int unsigned gap;
    gap = (tx_max == 0) ? 0 : $urandom_range(tx_max, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_data_byte      <= value;
    in_start_of_image <= sof;
    do @(posedge clk); while (in_stall);
    unfilter_byte(value, sof);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Sender pauses until every queued pixel has come back, then lets the
  // pipeline settle (filter bytes produce nothing to wait on).
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BYTES_PER_PIXEL) cfg_bpp = val[BPP_W-1:0];
    else if (idx == REG_ROW_LENGTH) cfg_row_len = val[ROW_LEN_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // A new row length may exceed what the previous row wrote to the store, so restart the image.
  task automatic set_row_length(input int val);
    write_reg(REG_ROW_LENGTH, val);
    need_sof = 1'b1;
  endtask

  function automatic logic [7:0] pick_byte(int mode);
    if (mode == DATA_NEAR) return 8'($urandom_range(3, 0));
    if (mode == DATA_EDGES) begin
      case ($urandom_range(5, 0))
        0:       return 8'h00;
        1:       return 8'h01;
        2:       return 8'h7F;
        3:       return 8'h80;
        4:       return 8'hFE;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom_range(255, 0));
  endfunction

  // Filter byte plus a full row of data, or only cut data bytes if cut >= 0.
  task automatic send_row(input logic [7:0] ftype, input logic sof, input int mode,
                          input int cut);
    int n;
    n = (cut < 0) ? int'(row_span()) : cut;
    send_byte(ftype, sof | need_sof);
    need_sof = 1'b0;
    repeat (n) send_byte(pick_byte(mode), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Registers at reset: one byte per pixel, one byte per row.
  task automatic test_reset_values();
    send_byte(8'(FLT_SUB), 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'(FLT_UP), 1'b0);
    send_byte(8'h05, 1'b0);
  endtask

  // Every filter type plus unknown codes, 3-byte rows, 2-byte pixels, with
  // carries out of bit 7 and the first-pixel zero neighbors.
  task automatic test_filter_types();
    logic [7:0] listed [0:6][0:3] = '{
      '{8'(FLT_SUB),            8'hFF, 8'h01, 8'h80},
      '{8'(FLT_UP),             8'h00, 8'hFF, 8'h7F},
      '{8'(FLT_AVG),            8'h01, 8'h80, 8'hFF},
      '{8'(FLT_PAETH),          8'h80, 8'h7F, 8'h00},
      '{8'(FLT_NONE),           8'hFF, 8'h00, 8'h55},
      '{FLT_CODE_FIRST_UNKNOWN, 8'hAA, 8'h55, 8'hFF},
      '{FLT_CODE_TOP,           8'h01, 8'h02, 8'h03}
    };
    wait_idle();
    write_reg(REG_BYTES_PER_PIXEL, 2);
    write_reg(REG_ROW_LENGTH, 3);
    for (int r = 0; r < 7; r++) begin
      for (int k = 0; k < 4; k++) send_byte(listed[r][k], (r == 0 && k == 0));
    end
  endtask

  task automatic test_special_cases();
    wait_idle();
    write_reg(REG_BYTES_PER_PIXEL, 1);
    set_row_length(6);
    // start mark in the middle of a row: that byte opens a new first row
    send_row(FLT_PAETH, 1'b0, DATA_ANY, -1);
    send_row(FLT_UP, 1'b0, DATA_ANY, 3);
    send_row(FLT_UP, 1'b1, DATA_ANY, -1);
    send_row(FLT_AVG, 1'b0, DATA_ANY, -1);
    // row length lowered mid row: the next data byte closes the row
    send_row(FLT_PAETH, 1'b0, DATA_ANY, 2);
    wait_idle();
    write_reg(REG_ROW_LENGTH, 1);
    send_byte(pick_byte(DATA_ANY), 1'b0);
    send_row(FLT_SUB, 1'b0, DATA_ANY, -1);
    // zero registers act as one
    wait_idle();
    write_reg(REG_BYTES_PER_PIXEL, 0);
    set_row_length(0);
    send_row(FLT_SUB, 1'b0, DATA_ANY, -1);
    send_row(FLT_UP, 1'b0, DATA_ANY, -1);
    // pixel size above the history depth clamps to eight
    wait_idle();
    write_reg(REG_BYTES_PER_PIXEL, 15);
    set_row_length(10);
    send_row(FLT_SUB, 1'b0, DATA_EDGES, -1);
    send_row(FLT_PAETH, 1'b0, DATA_EDGES, -1);
    // upper data bits of the pixel size and the spare indexes are dropped
    wait_idle();
    write_reg(REG_BYTES_PER_PIXEL, 14'h3FF3);
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    send_row(FLT_PAETH, 1'b0, DATA_NEAR, -1);
    send_row(FLT_AVG, 1'b0, DATA_NEAR, -1);
  endtask

  // Long rows at full rate with the widest pixel: a whole row of the store
  // written, then read back by the next row.
  task automatic test_register_extremes();
    wait_idle();
    tx_max = 0;
    rx_max = 0;
    write_reg(REG_BYTES_PER_PIXEL, MAX_PIXEL_BYTES);
    set_row_length(LONG_ROW);
    send_row(FLT_SUB, 1'b0, DATA_ANY, -1);
    send_row(FLT_PAETH, 1'b0, DATA_ANY, -1);
    wait_idle();
    tx_max = IDLE_MAX;
    rx_max = IDLE_MAX;
  endtask

  // Random images: mostly well-formed rows with random content, some unknown
  // filter codes, truncated rows cut off by a start mark, pixel size changes
  // between rows. Each image gets its own idle profile.
  task automatic test_random_images();
    int unsigned goal, rows;
    int          mode, cut;
    logic [7:0]  ftype;
    goal = bytes_sent + 1100;
    while (bytes_sent < goal) begin
      wait_idle();
      case ($urandom_range(2, 0))
        0:       tx_max = 0;
        1:       tx_max = IDLE_MAX;
        default: tx_max = $urandom_range(IDLE_MAX, 1);
      endcase
      case ($urandom_range(2, 0))
        0:       rx_max = 0;
        1:       rx_max = IDLE_MAX;
        default: rx_max = $urandom_range(IDLE_MAX, 1);
      endcase
      if ($urandom_range(3, 0) == 0) write_reg(REG_BYTES_PER_PIXEL, $urandom_range(16383, 0));
      else write_reg(REG_BYTES_PER_PIXEL, $urandom_range(MAX_PIXEL_BYTES, 1));
      case ($urandom_range(9, 0))
        0:       set_row_length(0);
        1:       set_row_length($urandom_range(300, 25));
        default: set_row_length($urandom_range(24, 1));
      endcase
      rows = $urandom_range(6, 1);
      repeat (rows) begin
        ftype = ($urandom_range(7, 0) == 0) ? 8'($urandom_range(255, FLT_CODE_FIRST_UNKNOWN))
                                            : 8'($urandom_range(FLT_PAETH, FLT_NONE));
        mode = ($urandom_range(1, 0) != 0) ? DATA_ANY
             : (($urandom_range(1, 0) != 0) ? DATA_EDGES : DATA_NEAR);
        if ($urandom_range(9, 0) == 0) begin
          cut = $urandom_range(row_span() - 1, 0);
          send_row(ftype, 1'b0, mode, cut);
          need_sof = 1'b1;
        end else begin
          send_row(ftype, 1'b0, mode, -1);
        end
        if ($urandom_range(15, 0) == 0) begin
          wait_idle();
          write_reg(REG_BYTES_PER_PIXEL, $urandom_range(MAX_PIXEL_BYTES, 1));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_values();
    test_filter_types();
    test_special_cases();
    test_register_extremes();
    test_random_images();

    wait_idle();
    repeat (10) @(negedge clk);

    $display("%0d stream bytes sent, %0d pixel bytes checked over %0d rows",
             bytes_sent, pixels_checked, rows_closed);
    $display("all filter types, unknown codes, mid-row start marks, shortened rows,"
             , " clamped pixel sizes and long full-rate rows exercised");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- png_scanline_unfilter_top.f -----
rtl/psu_pkg.sv
rtl/psu_ram.sv
rtl/psu_ctrl.sv
rtl/psu_recon.sv
rtl/png_scanline_unfilter_top.sv
tb/sv/png_scanline_unfilter_top_test.sv
